// File: rtl/ccpd_pkg.sv
// Package for the caption control pair decoder.
// Holds request and result types, kind codes and the preamble row table.
// No dependencies.
package ccpd_pkg;

  typedef struct packed {
    logic [6:0] byte_first;
    logic [6:0] byte_second;
  } ccpd_req_t;

  typedef struct packed {
    logic [2:0] code_kind;
    logic [3:0] row;
    logic [2:0] color_index;
    logic       italic;
    logic       underline;
    logic [4:0] indent_col;
    logic       semi_transparent;
    logic [1:0] tab_columns;
  } ccpd_res_t;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_PAC    = 3'd1;
  localparam logic [2:0] KIND_MIDROW = 3'd2;
  localparam logic [2:0] KIND_BG     = 3'd3;
  localparam logic [2:0] KIND_TAB    = 3'd4;
  localparam logic [2:0] KIND_BT     = 3'd5;

  localparam logic [6:0] FIRST_MIDROW = 7'h11;
  localparam logic [6:0] FIRST_BG     = 7'h10;
  localparam logic [6:0] FIRST_EXT    = 7'h17;
  localparam logic [6:0] SECOND_BT    = 7'h2D;
  localparam logic [6:0] SECOND_TAB_LO = 7'h21;
  localparam logic [6:0] SECOND_TAB_HI = 7'h23;
  localparam logic [3:0] ROW_ALONE    = 4'd11;
  localparam logic [3:0] SUB_ITALIC   = 4'd7;

  // First row of the row pair selected by the low bits of the first byte.
  function automatic logic [3:0] pac_pair_row(input logic [2:0] sel);
    logic [3:0] r;
    case (sel)
      3'd0: r = 4'd11;
      3'd1: r = 4'd1;
      3'd2: r = 4'd3;
      3'd3: r = 4'd12;
      3'd4: r = 4'd14;
      3'd5: r = 4'd5;
      3'd6: r = 4'd7;
      3'd7: r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/caption_control_pair_decoder.sv
// Caption control pair decoder, channel 1 control codes.
// Two register stages (input, result); out_valid comes from the result register.
// Throughput: one request per cycle while out_stall is low; the decode sets no limit.
// A stalled result holds in the result register while the input register takes one more.
// Reset (rst_n low, synchronous) empties both registers; payload registers are not cleared.
// Depends on ccpd_pkg.
module caption_control_pair_decoder
  import ccpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ccpd_req_t in_req,
  output logic      out_valid,
  input  logic      out_stall,
  output ccpd_res_t out_result
);

  logic      s1_valid_r;
  ccpd_req_t s1_req_r;
  logic      s2_valid_r;
  ccpd_res_t s2_res_r;
  ccpd_res_t res_nxt;
  logic      s2_load;
  logic      s1_load;

  // Result register frees up when empty or being taken.
  assign s2_load  = !s2_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s2_load;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load || s2_load) begin
      s1_valid_r <= s1_load;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_req_r <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      s2_res_r <= res_nxt;
    end
  end

  // Decode
  logic [6:0] a;
  logic [6:0] b;
  logic [3:0] sub;
  logic [3:0] pair_row;
  logic       pac_hit;
  logic       midrow_hit;
  logic       bg_hit;
  logic       tab_hit;
  logic       bt_hit;

  assign a        = s1_req_r.byte_first;
  assign b        = s1_req_r.byte_second;
  assign sub      = b[4:1];
  assign pair_row = pac_pair_row(a[2:0]);

  // Row 11 has no partner row; drop the pair when the row-pair bit is set.
  assign pac_hit    = (a[6:3] == 4'b0010) && b[6] && !((pair_row == ROW_ALONE) && b[5]);
  assign midrow_hit = (a == FIRST_MIDROW) && (b[6:4] == 3'b010);
  assign bg_hit     = (a == FIRST_BG) && (b[6:4] == 3'b010);
  assign tab_hit    = (a == FIRST_EXT) && (b >= SECOND_TAB_LO) && (b <= SECOND_TAB_HI);
  assign bt_hit     = (a == FIRST_EXT) && (b == SECOND_BT);

  always_comb begin
    res_nxt = '0;
    if (a[6:3] == 4'b0010 && b[6]) begin
      if (pac_hit) begin
        res_nxt.code_kind = KIND_PAC;
        res_nxt.row       = pair_row + {3'b000, b[5]};
        res_nxt.underline = b[0];
        if (sub[3]) begin
          res_nxt.indent_col = {sub[2:0], 2'b00};
        end else if (sub == SUB_ITALIC) begin
          res_nxt.italic = 1'b1;
        end else begin
          res_nxt.color_index = sub[2:0];
        end
      end
    end else if (midrow_hit) begin
      res_nxt.code_kind = KIND_MIDROW;
      res_nxt.underline = b[0];
      if (b[3:1] == SUB_ITALIC[2:0]) begin
        res_nxt.italic = 1'b1;
      end else begin
        res_nxt.color_index = b[3:1];
      end
    end else if (bg_hit) begin
      res_nxt.code_kind        = KIND_BG;
      res_nxt.color_index      = b[3:1];
      res_nxt.semi_transparent = b[0];
    end else if (tab_hit) begin
      res_nxt.code_kind   = KIND_TAB;
      res_nxt.tab_columns = b[1:0];
    end else if (bt_hit) begin
      res_nxt.code_kind = KIND_BT;
    end
  end

  assign out_valid  = s2_valid_r;
  assign out_result = s2_res_r;

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !s2_valid_r)
    else $error("pipeline not empty after reset");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.code_kind == KIND_NONE |->
      out_result.row == 4'd0 && out_result.color_index == 3'd0 &&
      !out_result.italic && !out_result.underline && out_result.indent_col == 5'd0 &&
      !out_result.semi_transparent && out_result.tab_columns == 2'd0)
    else $error("unrecognized pair carries nonzero fields");

  a_row_pac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_result.row != 4'd0) == (out_result.code_kind == KIND_PAC)))
    else $error("row set outside preamble code");

  a_tab_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.tab_columns != 2'd0 |-> out_result.code_kind == KIND_TAB)
    else $error("tab columns set outside tab offset");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_load |=> s1_valid_r && $stable(s1_req_r))
    else $error("input register lost a held request");
`endif

endmodule
